### src/swmm_pkg.sv
// Shared types and constants of the sliding window max/min filter.
// No dependencies; compiled before every other file of the block.
package swmm_pkg;

   localparam int CFG_BITS = 4;
   localparam logic [CFG_BITS-1:0] WIDTH_RESET = 4'd5;
   localparam int WIDTH_FLOOR = 3;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

### src/swmm_if.sv
// Valid/ready channel interfaces of the sliding window max/min filter.
// No dependencies; one interface for sample transactions, one for results.
interface swmm_req_if #(parameter int SAMPLE_BITS = 8);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   line_end;

   modport source (output valid, sample, line_end, input ready);
   modport sink (input valid, sample, line_end, output ready);
endinterface

interface swmm_rsp_if #(parameter int SAMPLE_BITS = 8);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] max_value;
   logic [SAMPLE_BITS-1:0] min_value;
   logic                   last_of_line;

   modport source (output valid, max_value, min_value, last_of_line, input ready);
   modport sink (input valid, max_value, min_value, last_of_line, output ready);
endinterface

### src/swmm_cell.sv
// One cell of the filter chain: one history sample and one accumulator stage.
// Depends on swmm_pkg.
module swmm_cell #(
   parameter int SAMPLE_BITS = 8,
   parameter int AGE_BITS    = 4,
   parameter int CELL_INDEX  = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic                   advance,
   input  logic [SAMPLE_BITS-1:0] sample_in,
   output logic [SAMPLE_BITS-1:0] sample_out,
   input  swmm_pkg::tag_type      tag_in,
   output swmm_pkg::tag_type      tag_out,
   input  logic [AGE_BITS-1:0]    top_in,
   output logic [AGE_BITS-1:0]    top_out,
   input  logic [SAMPLE_BITS-1:0] max_in,
   input  logic [SAMPLE_BITS-1:0] min_in,
   output logic [SAMPLE_BITS-1:0] max_out,
   output logic [SAMPLE_BITS-1:0] min_out
);
   import swmm_pkg::*;

   logic [SAMPLE_BITS-1:0] sample_ff;
   tag_type                tag_ff;
   logic [AGE_BITS-1:0]    top_ff;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] max_in_c;
   logic [SAMPLE_BITS-1:0] min_in_c;
   logic                   take;

   assign take     = top_in >= AGE_BITS'(CELL_INDEX);
   assign max_in_c = (take && (sample_ff > max_in)) ? sample_ff : max_in;
   assign min_in_c = (take && (sample_ff < min_in)) ? sample_ff : min_in;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_in;
      end
      if (advance) begin
         top_ff <= top_in;
         max_ff <= max_in_c;
         min_ff <= min_in_c;
      end
   end

   assign sample_out = sample_ff;
   assign tag_out    = tag_ff;
   assign top_out    = top_ff;
   assign max_out    = max_ff;
   assign min_out    = min_ff;

endmodule

### src/swmm_ctrl.sv
// Line tracking and query issue for the filter chain.
// Depends on swmm_pkg; drives the head of the chain of swmm_cell.
module swmm_ctrl #(
   parameter int MAX_WIDTH = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [swmm_pkg::CFG_BITS-1:0]     csr_width,
   input  logic                              accept,
   input  logic                              line_end,
   input  logic                              advance,
   input  logic                              retire,
   output logic                              idle,
   output swmm_pkg::tag_type                 issue_tag,
   output logic [$clog2(MAX_WIDTH)-1:0]      issue_top
);
   import swmm_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int XW = (CW > CFG_BITS) ? CW : CFG_BITS;
   localparam int SW = ((CW > AW) ? CW : AW) + 1;

   logic [CW-1:0] line_fill_ff, line_fill_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [AW-1:0] ofs_ff, ofs_in;
   logic [AW-1:0] span_ff, span_in;
   logic          flush_ff, flush_in;
   logic [CW-1:0] inflight_ff, inflight_in;

   logic [XW-1:0] width_clip;
   logic [XW-1:0] width_eff;
   logic [XW-1:0] half;
   logic [CW-1:0] fill_new;
   logic [XW-1:0] fill_x;
   logic [SW-1:0] reach;
   logic          issue;

   always_comb begin
      width_clip = (XW'(csr_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(csr_width);
      width_eff  = (width_clip < XW'(WIDTH_FLOOR)) ? XW'(WIDTH_FLOOR) : width_clip;
      half       = (width_eff >> 1) + XW'(width_eff[0]);
      fill_new   = (line_fill_ff < CW'(MAX_WIDTH)) ? line_fill_ff + 1'b1 : line_fill_ff;
      fill_x     = XW'(fill_new);
   end

   assign issue = advance && (rem_ff != '0);
   assign reach = SW'(rem_ff) + SW'(ofs_ff) - SW'(1);

   assign issue_tag.valid = rem_ff != '0;
   assign issue_tag.last  = flush_ff && (rem_ff == CW'(1));
   assign issue_top       = (reach > SW'(span_ff)) ? span_ff : AW'(reach);
   assign idle            = (rem_ff == '0) && (inflight_ff == '0);

   always_comb begin
      line_fill_in = line_fill_ff;
      rem_in       = rem_ff;
      ofs_in       = ofs_ff;
      span_in      = span_ff;
      flush_in     = flush_ff;
      if (accept) begin
         span_in = AW'(fill_new - 1'b1);
         if (line_end) begin
            line_fill_in = '0;
            rem_in       = (fill_x < half) ? fill_new : CW'(half);
            ofs_in       = AW'(width_eff - half);
            flush_in     = 1'b1;
         end else begin
            line_fill_in = fill_new;
            rem_in       = (fill_x >= half) ? CW'(1) : '0;
            ofs_in       = AW'(width_eff - XW'(1));
            flush_in     = 1'b0;
         end
      end else if (issue) begin
         rem_in = rem_ff - 1'b1;
      end
      case ({issue, retire})
         2'b10:   inflight_in = inflight_ff + 1'b1;
         2'b01:   inflight_in = inflight_ff - 1'b1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_fill_ff <= '0;
         rem_ff       <= '0;
         flush_ff     <= 1'b0;
         inflight_ff  <= '0;
      end else begin
         line_fill_ff <= line_fill_in;
         rem_ff       <= rem_in;
         flush_ff     <= flush_in;
         inflight_ff  <= inflight_in;
      end
      ofs_ff  <= ofs_in;
      span_ff <= span_in;
   end

endmodule

### src/sliding_window_max_min_filter_unit.sv
// Running max/min filter over one line of samples, clipped at both line ends.
// Depends on swmm_pkg, swmm_if, swmm_ctrl and swmm_cell.
//
// Samples enter one transaction at a time; the history is a row of MAX_WIDTH cells that shift
// on each accepted sample. Every result is a query that walks the row one cell per cycle while
// the result side does not stall, folding in the samples of its window; the results of one
// sample issue one after another. A sample that gives no result does not hold off the next
// sample; one that gives k results (k is 1 inside a line, up to (w+1)/2 on the sample marking
// line end) holds off the next sample until its last result has left the row of cells. The
// last flushed result of a line carries last_of_line. Write csr_write_data only while no
// transaction is in flight; widths outside 3..MAX_WIDTH are clamped.
module sliding_window_max_min_filter_unit #(
   parameter int MAX_WIDTH   = 15,
   parameter int SAMPLE_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [swmm_pkg::CFG_BITS-1:0] csr_write_data,
   swmm_req_if.sink                      req_bus,
   swmm_rsp_if.source                    rsp_bus
);
   import swmm_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [CFG_BITS-1:0]    width_ff;
   logic                   idle;
   logic                   accept;
   logic                   advance;
   logic                   retire;

   tag_type                link_tag [MAX_WIDTH+1];
   logic [AW-1:0]          link_top [MAX_WIDTH+1];
   logic [SAMPLE_BITS-1:0] link_max [MAX_WIDTH+1];
   logic [SAMPLE_BITS-1:0] link_min [MAX_WIDTH+1];
   logic [SAMPLE_BITS-1:0] hist     [MAX_WIDTH+1];

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_max_ff;
   logic [SAMPLE_BITS-1:0] rsp_min_ff;
   logic                   rsp_last_ff;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = idle;
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign retire        = advance && link_tag[MAX_WIDTH].valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_write_en) begin
         width_ff <= csr_write_data;
      end
   end

   swmm_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_width (width_ff),
      .accept    (accept),
      .line_end  (req_bus.line_end),
      .advance   (advance),
      .retire    (retire),
      .idle      (idle),
      .issue_tag (link_tag[0]),
      .issue_top (link_top[0])
   );

   assign hist[0]     = req_bus.sample;
   assign link_max[0] = '0;
   assign link_min[0] = '1;

   for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
      swmm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AW),
         .CELL_INDEX  (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .advance    (advance),
         .sample_in  (hist[k]),
         .sample_out (hist[k+1]),
         .tag_in     (link_tag[k]),
         .tag_out    (link_tag[k+1]),
         .top_in     (link_top[k]),
         .top_out    (link_top[k+1]),
         .max_in     (link_max[k]),
         .min_in     (link_min[k]),
         .max_out    (link_max[k+1]),
         .min_out    (link_min[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= link_tag[MAX_WIDTH].valid;
      end
      if (advance) begin
         rsp_max_ff  <= link_max[MAX_WIDTH];
         rsp_min_ff  <= link_min[MAX_WIDTH];
         rsp_last_ff <= link_tag[MAX_WIDTH].last;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.max_value    = rsp_max_ff;
   assign rsp_bus.min_value    = rsp_min_ff;
   assign rsp_bus.last_of_line = rsp_last_ff;

endmodule
